/* rtl/core/i2cdw_pkg.sv */
// ----------------------------------------------------------------------------
// i2cdw_pkg
// shared types and constants of the i2c display write serializer
// ----------------------------------------------------------------------------
package i2cdw_pkg;

  localparam int unsigned ADDR_W         = 7;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  // bus symbol codes
  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_BIT   = 2'd1;
  localparam logic [1:0] SYM_STOP  = 2'd2;

  // last bit of a nine-bit byte frame (released acknowledge slot)
  localparam logic [3:0] FRAME_LAST_BIT = 4'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              is_data;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       sda_level;
    logic       end_of_run;
  } out_word_t;

  // classified work for the back end
  typedef struct packed {
    logic              open_txn;
    logic [ADDR_W-1:0] addr;
    logic              is_data;
    logic              has_byte;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/core/i2cdw_front.sv */
// ----------------------------------------------------------------------------
// i2cdw_front
// accepts words, tracks the open transaction and builds commands
// ----------------------------------------------------------------------------
module i2cdw_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cdw_pkg::ADDR_W-1:0]        cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  i2cdw_pkg::in_word_t                 in_word,
  input  i2cdw_pkg::fifo_stat_t               fifo_stat,
  output logic                                cmd_push,
  output i2cdw_pkg::cmd_t                     cmd
);

  logic                         open_r, open_nxt;
  logic [i2cdw_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                         accept;

  assign in_full = fifo_stat.full;
  assign accept  = in_push && !fifo_stat.full;

  always_comb begin
    cmd.open_txn  = !open_r;
    cmd.addr      = addr_r;
    cmd.is_data   = in_word.is_data;
    cmd.has_byte  = in_word.has_byte;
    cmd.data_byte = in_word.data_byte;
    cmd.last      = in_word.last;
    // an empty word inside an open transaction yields nothing
    cmd_push      = accept && (!open_r || in_word.has_byte || in_word.last);
    open_nxt      = accept ? !in_word.last : open_r;
    addr_nxt      = cfg_we ? cfg_data : addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      addr_r <= '0;
    end else begin
      open_r <= open_nxt;
      addr_r <= addr_nxt;
    end
  end

endmodule

/* rtl/core/i2cdw_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// i2cdw_cmd_fifo
// short command queue between front and back end
// ----------------------------------------------------------------------------
module i2cdw_cmd_fifo #(
  parameter int unsigned Depth = i2cdw_pkg::CMD_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  i2cdw_pkg::cmd_t       wr_cmd,
  input  logic                  pop,
  output i2cdw_pkg::cmd_t       rd_cmd,
  output i2cdw_pkg::fifo_stat_t stat
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2cdw_pkg::cmd_t mem_r [Depth];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == CntW'(Depth));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_cmd     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/i2cdw_back.sv */
// ----------------------------------------------------------------------------
// i2cdw_back
// symbol sequencer: start, address, control, data and stop phases
// ----------------------------------------------------------------------------
module i2cdw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cdw_pkg::cmd_t       rd_cmd,
  input  logic                  fifo_empty,
  output logic                  fifo_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output i2cdw_pkg::out_word_t  out_word
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_CTRL  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_STOP  = 3'd5;

  logic [2:0]                   phase_r, phase_nxt;
  logic [3:0]                   bit_r, bit_nxt;
  i2cdw_pkg::cmd_t              cur_r, cur_nxt;
  logic                         ov_r, ov_nxt;
  i2cdw_pkg::out_word_t         ow_r, ow_nxt;
  logic                         emit;
  logic [i2cdw_pkg::BYTE_W-1:0] byte_sel;
  logic                         frame_end;
  logic                         sda_bit;

  assign out_empty = !ov_r;
  assign out_word  = ow_r;
  assign emit      = (phase_r != PH_IDLE) && (!ov_r || out_pop);
  assign frame_end = (bit_r == i2cdw_pkg::FRAME_LAST_BIT);

  always_comb begin
    case (phase_r)
      PH_ADDR: byte_sel = {cur_r.addr, 1'b0};
      PH_CTRL: byte_sel = {1'b0, cur_r.is_data, 6'b0};
      default: byte_sel = cur_r.data_byte;
    endcase
    sda_bit = frame_end ? 1'b1 : byte_sel[3'(4'd7 - bit_r)];
  end

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    cur_nxt   = cur_r;
    fifo_pop  = 1'b0;
    ow_nxt    = ow_r;
    ov_nxt    = (ov_r && !out_pop);

    if (phase_r == PH_IDLE) begin
      if (!fifo_empty) begin
        fifo_pop = 1'b1;
        cur_nxt  = rd_cmd;
        bit_nxt  = '0;
        if (rd_cmd.open_txn) begin
          phase_nxt = PH_START;
        end else if (rd_cmd.has_byte) begin
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
    end else if (emit) begin
      ov_nxt            = 1'b1;
      ow_nxt.symbol     = i2cdw_pkg::SYM_BIT;
      ow_nxt.sda_level  = sda_bit;
      ow_nxt.end_of_run = 1'b0;
      bit_nxt           = frame_end ? 4'd0 : bit_r + 4'd1;
      case (phase_r)
        PH_START: begin
          ow_nxt.symbol    = i2cdw_pkg::SYM_START;
          ow_nxt.sda_level = 1'b0;
          bit_nxt          = '0;
          phase_nxt        = PH_ADDR;
        end
        PH_ADDR: begin
          if (frame_end) begin
            phase_nxt = PH_CTRL;
          end
        end
        PH_CTRL: begin
          if (frame_end) begin
            if (cur_r.has_byte) begin
              phase_nxt = PH_DATA;
            end else if (cur_r.last) begin
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt         = PH_IDLE;
              ow_nxt.end_of_run = 1'b1;
            end
          end
        end
        PH_DATA: begin
          if (frame_end) begin
            if (cur_r.last) begin
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt         = PH_IDLE;
              ow_nxt.end_of_run = 1'b1;
            end
          end
        end
        PH_STOP: begin
          ow_nxt.symbol     = i2cdw_pkg::SYM_STOP;
          ow_nxt.sda_level  = 1'b1;
          ow_nxt.end_of_run = 1'b1;
          phase_nxt         = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    bit_r <= bit_nxt;
    ow_r  <= ow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

/* rtl/core/i2c_display_write_serializer.sv */
// ----------------------------------------------------------------------------
// i2c_display_write_serializer
// write-only i2c master symbol stream for a display controller
// ----------------------------------------------------------------------------
// usage:
//   input channel: a word (data byte plus has_byte, is_data, last markers) is
//   taken when in_push is high and in_full is low
//   result channel: a bus symbol (start, clocked bit or stop) sits
//   on out_word while out_empty is low and leaves when out_pop is high
//   cfg_we/cfg_data set the seven-bit target address, written while idle
//   an opening word gives start, address and control frames (nine bits
//   each, ninth released), its data frame if it has a byte, a stop if last
// path: a word is queued, loaded by the sequencer, and its symbols registered
// throughput: one symbol per cycle from the sequencer while out_word is
//   free or popped; an open-transaction word takes nine bits plus a command
//   load, an opening word also a start plus address and control frames
// reset: transaction closed, address zero, queues and output emptied
// stall: when out_pop stays low the output register holds its symbol, the
//   sequencer waits, and in_full rises once the command queue fills
// ----------------------------------------------------------------------------
module i2c_display_write_serializer #(
  parameter int unsigned CmdFifoDepth = i2cdw_pkg::CMD_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [i2cdw_pkg::ADDR_W-1:0]  cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  i2cdw_pkg::in_word_t           in_word,
  output logic                          out_empty,
  input  logic                          out_pop,
  output i2cdw_pkg::out_word_t          out_word
);

  // front to queue
  logic                  cmd_push;
  i2cdw_pkg::cmd_t       cmd_wr;
  // queue to back
  logic                  cmd_pop;
  i2cdw_pkg::cmd_t       cmd_rd;
  i2cdw_pkg::fifo_stat_t fifo_stat;

  // front end: accept, track open transaction, classify
  i2cdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .fifo_stat (fifo_stat),
    .cmd_push  (cmd_push),
    .cmd       (cmd_wr)
  );

  // decoupling queue
  i2cdw_cmd_fifo #(
    .Depth (CmdFifoDepth)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd_wr),
    .pop    (cmd_pop),
    .rd_cmd (cmd_rd),
    .stat   (fifo_stat)
  );

  // back end: symbol sequencer with output register
  i2cdw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_cmd     (cmd_rd),
    .fifo_empty (fifo_stat.empty),
    .fifo_pop   (cmd_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_word   (out_word)
  );

  // no unused symbol code ever leaves the block
  a_sym_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word.symbol == i2cdw_pkg::SYM_START ||
                    out_word.symbol == i2cdw_pkg::SYM_BIT ||
                    out_word.symbol == i2cdw_pkg::SYM_STOP))
    else $error("illegal symbol code");

  // a start is always followed by header bits, never ends a run
  a_start_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.symbol == i2cdw_pkg::SYM_START) |->
      (!out_word.end_of_run && !out_word.sda_level))
    else $error("start symbol malformed");

  // a stop always closes the run of its word
  a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.symbol == i2cdw_pkg::SYM_STOP) |->
      (out_word.end_of_run && out_word.sda_level))
    else $error("stop symbol malformed");

  // the queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.full |-> !cmd_push)
    else $error("command queue overflow");

endmodule
